// ----- hw/rtl/etot_pkg.sv -----
// euler totient core: shared widths, microcode types and the control store
// no dependencies; used by etot_div, etot_seq and euler_totient_core
package etot_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int TOT_W      = DATA_WIDTH - 1;
    // trial divisors never pass sqrt(2^DATA_WIDTH) + 1
    localparam int P_W        = DATA_WIDTH / 2 + 1;
    localparam int SQ_W       = 2 * P_W;
    localparam int PC_W       = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV,
        OP_MUL_PM1,
        OP_MUL_P,
        OP_MUL_MM1,
        OP_INC_P,
        OP_CLR,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NOSTART,
        C_MLE1,
        C_PSQGT,
        C_DIVBUSY,
        C_REMNZ
    } t_cond;

    typedef enum logic [PC_W-1:0] {
        S_IDLE,
        S_CHK,
        S_LOOP,
        S_DIV,
        S_WAIT,
        S_TEST,
        S_FIRST,
        S_DIV2,
        S_WAIT2,
        S_TEST2,
        S_MORE,
        S_NEXTP,
        S_TAIL,
        S_TAILM,
        S_DONE,
        S_ZERO
    } t_step;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic start;
        logic m_le1;
        logic psq_gt;
        logic div_busy;
        logic rem_nz;
    } t_status;

    // control store: one word per step, jump taken when the condition holds
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        unique case (s)
            S_IDLE:  w = '{OP_LOAD,    C_NOSTART, S_IDLE};
            S_CHK:   w = '{OP_NOP,     C_MLE1,    S_ZERO};
            S_LOOP:  w = '{OP_NOP,     C_PSQGT,   S_TAIL};
            S_DIV:   w = '{OP_DIV,     C_NONE,    S_IDLE};
            S_WAIT:  w = '{OP_NOP,     C_DIVBUSY, S_WAIT};
            S_TEST:  w = '{OP_NOP,     C_REMNZ,   S_NEXTP};
            S_FIRST: w = '{OP_MUL_PM1, C_NONE,    S_IDLE};
            S_DIV2:  w = '{OP_DIV,     C_NONE,    S_IDLE};
            S_WAIT2: w = '{OP_NOP,     C_DIVBUSY, S_WAIT2};
            S_TEST2: w = '{OP_NOP,     C_REMNZ,   S_NEXTP};
            S_MORE:  w = '{OP_MUL_P,   C_ALWAYS,  S_DIV2};
            S_NEXTP: w = '{OP_INC_P,   C_ALWAYS,  S_LOOP};
            S_TAIL:  w = '{OP_NOP,     C_MLE1,    S_DONE};
            S_TAILM: w = '{OP_MUL_MM1, C_NONE,    S_IDLE};
            S_DONE:  w = '{OP_OUT,     C_ALWAYS,  S_IDLE};
            S_ZERO:  w = '{OP_CLR,     C_ALWAYS,  S_DONE};
            default: w = '{OP_NOP,     C_ALWAYS,  S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/etot_div.sv -----
// etot_div: restoring divider, one quotient bit per cycle
// depends on etot_pkg for widths
module etot_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [etot_pkg::DATA_WIDTH-1:0] i_dividend,
    input  logic [etot_pkg::P_W-1:0]        i_divisor,
    output logic                           o_busy,
    output logic [etot_pkg::DATA_WIDTH-1:0] o_quot,
    output logic [etot_pkg::P_W-1:0]        o_rem
);

    localparam int CNT_W = $clog2(etot_pkg::DATA_WIDTH + 1);

    logic [CNT_W-1:0]                r_cnt;
    logic [etot_pkg::DATA_WIDTH-1:0] r_quo;
    logic [etot_pkg::P_W-1:0]        r_rem;
    logic [etot_pkg::P_W-1:0]        r_dvs;
    logic [etot_pkg::P_W:0]          rem_sh;
    logic [etot_pkg::P_W:0]          rem_sub;
    logic                            fits;

    always_comb begin
        rem_sh  = {r_rem, r_quo[etot_pkg::DATA_WIDTH-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        fits    = rem_sh >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(etot_pkg::DATA_WIDTH);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[etot_pkg::DATA_WIDTH-2:0], fits};
            r_rem <= fits ? rem_sub[etot_pkg::P_W-1:0] : rem_sh[etot_pkg::P_W-1:0];
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

// ----- hw/rtl/etot_seq.sv -----
// etot_seq: step counter and control store walker with conditional jumps
// depends on etot_pkg for the microcode, step and status types
module etot_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  etot_pkg::t_status i_status,
    output etot_pkg::t_op     o_op,
    output logic              o_busy
);

    etot_pkg::t_step           r_pc;
    etot_pkg::t_step           n_pc;
    etot_pkg::t_uword          uw;
    logic [etot_pkg::PC_W-1:0] pc_inc;
    logic                      take;

    always_comb begin
        uw     = etot_pkg::ucode(r_pc);
        pc_inc = r_pc + etot_pkg::PC_W'(1);
        unique case (uw.cond)
            etot_pkg::C_NONE:    take = 1'b0;
            etot_pkg::C_ALWAYS:  take = 1'b1;
            etot_pkg::C_NOSTART: take = !i_status.start;
            etot_pkg::C_MLE1:    take = i_status.m_le1;
            etot_pkg::C_PSQGT:   take = i_status.psq_gt;
            etot_pkg::C_DIVBUSY: take = i_status.div_busy;
            etot_pkg::C_REMNZ:   take = i_status.rem_nz;
            default:             take = 1'b1;
        endcase
        n_pc = take ? uw.target : etot_pkg::t_step'(pc_inc);
    end

    always_comb begin
        o_op   = uw.op;
        o_busy = r_pc != etot_pkg::S_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= etot_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- hw/rtl/euler_totient_core.sv -----
// euler_totient_core: top level, trial-division datapath driven by etot_seq
// depends on etot_pkg, etot_div and etot_seq
//
// usage: put a value on i_value and raise start while busy is low; the beat
// is taken at that clock edge and busy rises on the next cycle. the block
// then factors |i_value| by trial division and, when done, shows the totient
// on o_totient for exactly one cycle with o_valid high; busy is already low
// in that cycle, so the next beat can be taken at its closing edge.
// inputs 0, 1 and -1 give 0. one item at a time.
// each trial divisor that fails walks S_LOOP, S_DIV, S_WAIT (held while
// the divider runs), S_TEST and S_NEXTP; each further division by a found
// prime walks S_MORE, S_DIV2, S_WAIT2 and S_TEST2. trial divisors run from
// 2 up to sqrt of the remaining cofactor, so a large prime input is the
// slowest case. the bit-serial divider sets the pace: one quotient bit
// per cycle.
// reset (synchronous, active low) returns the sequencer to idle and drops
// o_valid; an item in flight is lost. the receiver cannot stall: the result
// beat is shown once and must be taken in that cycle.
module euler_totient_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [etot_pkg::DATA_WIDTH-1:0] i_value,
    output logic                           o_valid,
    output logic [etot_pkg::TOT_W-1:0]     o_totient
);

    localparam int DW = etot_pkg::DATA_WIDTH;

    logic [DW-1:0]             r_m;
    logic [etot_pkg::P_W-1:0]  r_p;
    logic [etot_pkg::SQ_W-1:0] r_psq;
    logic [DW-1:0]             r_acc;
    logic [etot_pkg::TOT_W-1:0] r_tot;
    logic                      r_valid;

    logic [DW-1:0]             mag;
    logic [DW-1:0]             mul_opnd;
    logic [2*DW-1:0]           prod;
    logic                      div_start;
    logic                      div_busy;
    logic [DW-1:0]             div_quot;
    logic [etot_pkg::P_W-1:0]  div_rem;
    etot_pkg::t_op             op;
    etot_pkg::t_status         status;

    always_comb begin
        mag = i_value[DW-1] ? (~i_value + DW'(1)) : i_value;
        case (op)
            etot_pkg::OP_MUL_PM1: mul_opnd = DW'(r_p - etot_pkg::P_W'(1));
            etot_pkg::OP_MUL_P:   mul_opnd = DW'(r_p);
            default:              mul_opnd = r_m - DW'(1);
        endcase
        prod      = r_acc * mul_opnd;
        div_start = op == etot_pkg::OP_DIV;

        status.start    = start;
        status.m_le1    = r_m[DW-1:1] == '0;
        status.psq_gt   = r_psq > etot_pkg::SQ_W'(r_m);
        status.div_busy = div_busy;
        status.rem_nz   = div_rem != '0;
    end

    etot_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_op     (op),
        .o_busy   (busy)
    );

    etot_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_m),
        .i_divisor  (r_p),
        .o_busy     (div_busy),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        case (op) inside
            etot_pkg::OP_LOAD: begin
                r_m   <= mag;
                r_p   <= etot_pkg::P_W'(2);
                r_psq <= etot_pkg::SQ_W'(4);
                r_acc <= DW'(1);
            end
            etot_pkg::OP_MUL_PM1, etot_pkg::OP_MUL_P: begin
                r_acc <= prod[DW-1:0];
                r_m   <= div_quot;
            end
            etot_pkg::OP_MUL_MM1: begin
                r_acc <= prod[DW-1:0];
            end
            etot_pkg::OP_INC_P: begin
                // (p+1)^2 = p^2 + 2p + 1
                r_p   <= r_p + etot_pkg::P_W'(1);
                r_psq <= r_psq + etot_pkg::SQ_W'({r_p, 1'b1});
            end
            etot_pkg::OP_CLR: begin
                r_acc <= '0;
            end
            etot_pkg::OP_OUT: begin
                r_tot <= r_acc[etot_pkg::TOT_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= op == etot_pkg::OP_OUT;
        end
    end

    assign o_valid   = r_valid;
    assign o_totient = r_tot;

`ifndef SYNTH
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start work");

    a_div_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> busy)
        else $error("divider running while sequencer idle");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beat repeated");
`endif

endmodule
